FILE: rtl/core/acps_pkg.sv
package acps_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int X_W = 18;
  localparam int ANGLE_W = 15;
  localparam int HALF_TURN = 16384;

  localparam longint unsigned C3_Q32 = 64'd80441731;
  localparam longint unsigned C2_Q32 = 64'd318948566;
  localparam longint unsigned C1_Q32 = 64'd911024411;
  localparam longint unsigned C0_Q32 = 64'd6746228827;
  localparam longint unsigned K_Q32  = 64'd22399066949078;

  // round a q32 constant half up to qf
  function automatic longint unsigned q32_to_qf(input longint unsigned k, input int f);
    q32_to_qf = (k + (64'd1 << (31 - f))) >> (32 - f);
  endfunction

endpackage

FILE: rtl/core/acps_if.sv
interface acps_in_if;
  import acps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;
  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface acps_out_if;
  import acps_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic               clamped;
  modport source (output valid, output angle, output clamped, input ready);
  modport sink   (input valid, input angle, input clamped, output ready);
endinterface

FILE: rtl/core/acps_sqrt_cell.sv
// one square root step by trial squaring against the radicand: one result bit per cell
module acps_sqrt_cell import acps_pkg::*; #(
  parameter int RW  = 17,
  parameter int NW  = 34,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rem_in,
  input  logic [RW-1:0] root_in,
  output logic [NW-1:0] rem,
  output logic [RW-1:0] root
);
  logic [NW-1:0] trial;
  logic [RW-1:0] root_try;

  always_comb begin
    root_try = root_in | (RW'(1) << BIT);
    trial = NW'(root_try) * NW'(root_try);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (trial <= rem_in) root <= root_try;
      else root <= root_in;
      rem <= rem_in;
    end
  end
endmodule

FILE: rtl/core/arccos_poly_sqrt_unit.sv
// arccos_poly_sqrt_unit: arccosine of a signed qF cosine
// input channel in_ch carries x_value; output channel out_ch carries
// angle (16384 = 180 degrees) and the clamped flag
// a row of square root cells, one result bit each, carries the horner
// steps and feeds a short chain of scaling stages; every stage advances together
// throughput: one beat per cycle while no output stall holds the row
// the whole row moves only when the last stage is empty or being drained,
// so a stall at the output holds every stage and in_ch.ready falls
// reset clears all stage valid bits; payload registers are not reset
// the square root row sets the latency, one cell per root bit
module arccos_poly_sqrt_unit import acps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  acps_in_if.sink    in_ch,
  acps_out_if.source out_ch
);
  localparam int F   = FRAC_BITS;
  localparam int RW  = F + 1;          // root width
  localparam int NW  = 2 * F + 2;      // radicand width
  localparam int AW  = F + 2;          // magnitude width
  localparam int PW  = F + 4;          // poly word, signed
  localparam int NS  = RW + 5;         // total stages
  localparam longint unsigned C3 = q32_to_qf(C3_Q32, F);
  localparam longint unsigned C2 = q32_to_qf(C2_Q32, F);
  localparam longint unsigned C1 = q32_to_qf(C1_Q32, F);
  localparam longint unsigned C0 = q32_to_qf(C0_Q32, F);
  localparam longint unsigned KQ = q32_to_qf(K_Q32, F);
  localparam int KW = F + 14;

  logic adv;
  logic [NS-1:0] vld;
  logic [NS-1:0] vld_next;

  assign adv = !vld[NS-1] || out_ch.ready;
  assign in_ch.ready = adv;

  // front: magnitude and clamp
  logic [X_W:0] mag_raw;
  logic         neg0;
  logic [AW-1:0] mag0;
  logic          clamp0;
  always_comb begin
    neg0 = in_ch.x_value[X_W-1];
    mag_raw = neg0 ? (X_W+1)'(-$signed({in_ch.x_value[X_W-1], in_ch.x_value}))
                   : (X_W+1)'({1'b0, in_ch.x_value});
    if ((X_W+1 > F) && (64'(mag_raw) > (64'd1 << F))) begin
      mag0 = AW'(64'd1 << F);
      clamp0 = 1'b1;
    end else begin
      mag0 = AW'(mag_raw);
      clamp0 = 1'b0;
    end
  end

  // per stage side data
  logic [AW-1:0]  a_s   [3];
  logic           neg_s [RW+1];
  logic           clp_s [RW+1];
  logic [NW-1:0]  rem0;
  logic [NW-1:0]  rem_s [RW+1];
  logic [RW-1:0]  root_s[RW+1];
  logic signed [PW-1:0] r_s [RW+1];

  // stage 0 register
  always_ff @(posedge clk) begin
    if (adv) begin
      a_s[0]    <= mag0;
      neg_s[0]  <= neg0;
      clp_s[0]  <= clamp0;
      rem0      <= NW'((64'd1 << F) - 64'(mag0)) << F;
      r_s[0]    <= -PW'(signed'(C3));
    end
  end
  assign rem_s[0]  = rem0;
  assign root_s[0] = '0;

  // sqrt row with horner steps riding on the first three cells
  for (genvar i = 0; i < RW; i++) begin : g_row
    acps_sqrt_cell #(.RW(RW), .NW(NW), .BIT(RW-1-i)) u_cell (
      .clk(clk), .en(adv), .rem_in(rem_s[i]), .root_in(root_s[i]),
      .rem(rem_s[i+1]), .root(root_s[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        neg_s[i+1] <= neg_s[i];
        clp_s[i+1] <= clp_s[i];
      end
    end
    if (i < 2) begin : g_mag
      always_ff @(posedge clk) begin
        if (adv) a_s[i+1] <= a_s[i];
      end
    end
    if (i < 3) begin : g_horner
      logic signed [PW+AW:0] prod;
      assign prod = r_s[i] * $signed({1'b0, a_s[i]});
      always_ff @(posedge clk) begin
        if (adv) begin
          if (i == 0)
            r_s[i+1] <= PW'(prod >>> F) + PW'(C2);
          else if (i == 1)
            r_s[i+1] <= PW'(prod >>> F) - PW'(C1);
          else
            r_s[i+1] <= PW'(prod >>> F) + PW'(C0);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (adv) r_s[i+1] <= r_s[i];
      end
    end
  end

  // back end: t = r*s >> F, v = t*K >> 2F, limit, fold
  logic [F+2:0]  r_pos;
  logic [F+2:0]  t_q;
  logic [2*F+4:0] ts;
  logic [F+2+KW:0] vp;
  logic [F+2+KW:0] vp_q;
  logic [ANGLE_W-1:0] v_q;
  logic [ANGLE_W-1:0] ang_q;
  logic [ANGLE_W-1:0] v_c;
  logic n1, n2, n3, c1, c2, c3;

  assign r_pos = r_s[RW][PW-1] ? '0 : (F+3)'(r_s[RW]);
  assign ts = (2*F+5)'(r_pos) * (2*F+5)'(root_s[RW]);
  assign vp = (F+3+KW)'(t_q) * (F+3+KW)'(KQ);
  always_comb begin
    if ((vp_q >> (2*F)) > (F+3+KW)'(HALF_TURN)) v_c = ANGLE_W'(HALF_TURN);
    else v_c = ANGLE_W'(vp_q >> (2*F));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_q   <= (F+3)'(ts >> F);
      n1 <= neg_s[RW]; c1 <= clp_s[RW];
      vp_q  <= vp;
      n2 <= n1; c2 <= c1;
      v_q   <= v_c;
      n3 <= n2; c3 <= c2;
      ang_q <= n3 ? ANGLE_W'(HALF_TURN) - v_q : v_q;
      out_ch.clamped <= c3;
    end
  end
  assign out_ch.angle = ang_q;

  always_comb begin
    vld_next = {vld[NS-2:0], in_ch.valid};
  end
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= vld_next;
  end
  assign out_ch.valid = vld[NS-1];
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import acps_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;

  // one expected result beat
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               clamped;
  } angle_beat_t;

  // q32 constant rounded half up to q16
  function automatic longint to_q16(input longint unsigned k);
    longint unsigned half;
    half = 64'd1 << (31 - FB);
    return longint'((k + half) >> (32 - FB));
  endfunction

  // floor of the square root, bit by bit
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned acc;
    longint unsigned b;
    acc = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= acc + b) begin
        n = n - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  // arccosine of one q16 cosine in half-turn units
  function automatic angle_beat_t predict_arccos(input logic signed [X_W-1:0] x);
    angle_beat_t res;
    longint mag;
    longint poly;
    longint unsigned root, t, v;
    logic neg;
    neg = x[X_W-1];
    mag = neg ? -longint'(x) : longint'(x);
    res.clamped = 1'b0;
    if (mag > ONE) begin
      mag = ONE;
      res.clamped = 1'b1;
    end
    // horner with floor-truncated products
    poly = -to_q16(C3_Q32);
    poly = ((poly * mag) >>> FB) + to_q16(C2_Q32);
    poly = ((poly * mag) >>> FB) - to_q16(C1_Q32);
    poly = ((poly * mag) >>> FB) + to_q16(C0_Q32);
    if (poly < 0) poly = 0;
    root = root_floor(longint'(ONE - mag) << FB);
    t = (longint'(poly) * root) >> FB;
    v = (t * to_q16(K_Q32)) >> (2 * FB);
    if (v > HALF_TURN) v = HALF_TURN;
    res.angle = neg ? ANGLE_W'(HALF_TURN - v) : ANGLE_W'(v);
    return res;
  endfunction

  // in-order store of pending angles
  class AngleScoreboard;
    angle_beat_t pending[$];
    int errors = 0;
    int matched = 0;
    int clamps = 0;

    function void note_input(input logic signed [X_W-1:0] x);
      pending.push_back(predict_arccos(x));
    endfunction

    function void check_result(input logic [ANGLE_W-1:0] angle, input logic clamped);
      angle_beat_t exp_b;
      if (pending.size() == 0) begin
        $error("unexpected result beat: angle %0d clamped %0d", angle, clamped);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (angle !== exp_b.angle) begin
        $error("angle: expected %0d, actual %0d", exp_b.angle, angle);
        errors++;
      end
      if (clamped !== exp_b.clamped) begin
        $error("clamped: expected %0d, actual %0d", exp_b.clamped, clamped);
        errors++;
      end
      matched++;
      if (exp_b.clamped) clamps++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  acps_in_if  in_ch();
  acps_out_if out_ch();

  arccos_poly_sqrt_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  AngleScoreboard angles = new();

  // sender: percent of beats with an idle gap in front; receiver: percent of cycles stalled
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.x_value = '0;
    out_ch.ready  = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // both monitors sample pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) angles.note_input(in_ch.x_value);
      if (out_ch.valid && out_ch.ready) angles.check_result(out_ch.angle, out_ch.clamped);
    end
  end

  // one input beat, with an optional idle gap in front
  task automatic send_cosine(input logic signed [X_W-1:0] x);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_value <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // mostly legal cosines, some out of range, some near the ends
  function automatic logic signed [X_W-1:0] pick_cosine();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return X_W'($urandom_range(131072) - 65536);
    if (sel < 85) return X_W'($urandom());
    if (sel < 95) return X_W'($urandom_range(65536, 65536 - 64));
    return -X_W'($urandom_range(65536, 65536 - 64));
  endfunction

  logic signed [X_W-1:0] corner_vals[$] = '{
    18'sd0, 18'sd1, -18'sd1, 18'sd65536, -18'sd65536, 18'sd65535, -18'sd65535,
    18'sd65537, -18'sd65537, 18'sd131071, -18'sd131072, -18'sd131071,
    18'sd32768, -18'sd32768, 18'sd16384, -18'sd16384, 18'sd49152, -18'sd49152,
    18'sd100000, -18'sd100000, 18'sd2, -18'sd2
  };

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners with no idling
    foreach (corner_vals[i]) send_cosine(corner_vals[i]);

    // sender slow, receiver slower; then swapped; then full rate
    tx_idle_pct = 35; rx_idle_pct = 79;
    repeat (530) send_cosine(pick_cosine());
    tx_idle_pct = 79; rx_idle_pct = 35;
    repeat (530) send_cosine(pick_cosine());
    tx_idle_pct = 0; rx_idle_pct = 0;
    repeat (540) send_cosine(pick_cosine());
    in_ch.valid <= 1'b0;

    // drain the pipeline, then allow for its latency
    while (angles.pending.size() != 0) @(posedge clk);
    repeat (4 * (FB + 6)) @(posedge clk);

    $display("tb: %0d arccos results checked, %0d of them clamped", angles.matched,
             angles.clamps);
    $display("tb: corners plus random cosines over three stall mixes");
    if (angles.errors == 0 && angles.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
